// File: rtl/hsv_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define HSVC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HSVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, hue constants, sector codes and the sector tag type.
// ----------------------------------------------------------------------------
package hsvc_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int IN_W          = 16;
	localparam int CHAN_W        = 15;
	localparam int HUE_W         = 15;
	localparam int REM_W         = 12;
	localparam int HUE_TURN      = 23040;

	localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t sector;
		logic    gray;
	} tag_t;

endpackage

// File: rtl/hsvc_front.sv
// ----------------------------------------------------------------------------
// HSV front end
// Stage 1 wraps hue and clamps saturation and value; stage 2 finds the
// sector, the remainder within it, and p = v * (1 - s).
// ----------------------------------------------------------------------------
module hsvc_front #(
	parameter int FRAC_BITS = hsvc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                hsv_valid,
	output logic                                hsv_ready,
	input  logic signed [hsvc_pkg::IN_W-1:0]    hue,
	input  logic signed [hsvc_pkg::IN_W-1:0]    saturation,
	input  logic signed [hsvc_pkg::IN_W-1:0]    brightness,
	output logic                                sec_valid,
	input  logic                                sec_ready,
	output hsvc_pkg::tag_t                      sec_tag,
	output logic [hsvc_pkg::REM_W-1:0]          sec_rem,
	output logic [FRAC_BITS:0]                  sec_s,
	output logic [FRAC_BITS:0]                  sec_v,
	output logic [FRAC_BITS:0]                  sec_p
);

	localparam int UW = FRAC_BITS + 1;
	localparam int PW = 2 * UW;
	localparam int HW = hsvc_pkg::IN_W + 1;
	localparam logic [UW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [UW-1:0] HALF = ONE >> 1;
	localparam logic signed [HW-1:0] TURN = HW'(hsvc_pkg::HUE_TURN);

	function automatic logic [UW-1:0] clamp_unit(input logic signed [hsvc_pkg::IN_W-1:0] x);
		logic [hsvc_pkg::IN_W-2:0] m;
		m = x[hsvc_pkg::IN_W-2:0];
		if (x <= 0) begin
			return '0;
		end
		if (m > ONE) begin
			return ONE;
		end
		return UW'(m);
	endfunction

	// Stage 1
	logic                          v_s1;
	logic [hsvc_pkg::HUE_W-1:0]    h_s1;
	logic [UW-1:0]                 s_s1;
	logic [UW-1:0]                 val_s1;
	logic                          s1_ready;

	logic signed [HW-1:0] h0, h1, h2;

	always_comb begin
		h0 = {hue[hsvc_pkg::IN_W-1], hue};
		if (h0 < 0) begin
			h1 = h0 + TURN;
		end else if (h0 >= TURN) begin
			h1 = h0 - TURN;
		end else begin
			h1 = h0;
		end
		if (h1 < 0) begin
			h2 = h1 + TURN;
		end else if (h1 >= TURN) begin
			h2 = h1 - TURN;
		end else begin
			h2 = h1;
		end
	end

	// Stage 2
	logic                          v_s2;
	hsvc_pkg::tag_t                tag_s2;
	logic [hsvc_pkg::REM_W-1:0]    rem_s2;
	logic [UW-1:0]                 s_s2;
	logic [UW-1:0]                 val_s2;
	logic [UW-1:0]                 p_s2;
	logic                          s2_ready;

	hsvc_pkg::sector_t             sec;
	logic [hsvc_pkg::HUE_W-1:0]    base;
	logic [hsvc_pkg::HUE_W-1:0]    rem_full;
	logic [PW-1:0]                 p_prod;

	always_comb begin
		priority if (h_s1 >= 5 * hsvc_pkg::HUE_SECTOR) begin
			sec  = hsvc_pkg::SEC_MAGENTA;
			base = hsvc_pkg::HUE_W'(5 * hsvc_pkg::HUE_SECTOR);
		end else if (h_s1 >= 4 * hsvc_pkg::HUE_SECTOR) begin
			sec  = hsvc_pkg::SEC_BLUE;
			base = hsvc_pkg::HUE_W'(4 * hsvc_pkg::HUE_SECTOR);
		end else if (h_s1 >= 3 * hsvc_pkg::HUE_SECTOR) begin
			sec  = hsvc_pkg::SEC_CYAN;
			base = hsvc_pkg::HUE_W'(3 * hsvc_pkg::HUE_SECTOR);
		end else if (h_s1 >= 2 * hsvc_pkg::HUE_SECTOR) begin
			sec  = hsvc_pkg::SEC_GREEN;
			base = hsvc_pkg::HUE_W'(2 * hsvc_pkg::HUE_SECTOR);
		end else if (h_s1 >= hsvc_pkg::HUE_SECTOR) begin
			sec  = hsvc_pkg::SEC_YELLOW;
			base = hsvc_pkg::HUE_SECTOR;
		end else begin
			sec  = hsvc_pkg::SEC_RED;
			base = '0;
		end
		rem_full = h_s1 - base;
		p_prod   = PW'(val_s1) * PW'(ONE - s_s1) + PW'(HALF);
	end

	assign s1_ready  = !v_s1 || s2_ready;
	assign s2_ready  = !v_s2 || sec_ready;
	assign hsv_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= hsv_valid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && hsv_valid) begin
			h_s1   <= h2[hsvc_pkg::HUE_W-1:0];
			s_s1   <= clamp_unit(saturation);
			val_s1 <= clamp_unit(brightness);
		end
		if (s2_ready && v_s1) begin
			tag_s2.sector <= sec;
			tag_s2.gray   <= (s_s1 == '0);
			rem_s2        <= rem_full[hsvc_pkg::REM_W-1:0];
			s_s2          <= s_s1;
			val_s2        <= val_s1;
			p_s2          <= p_prod[FRAC_BITS +: UW];
		end
	end

	assign sec_valid = v_s2;
	assign sec_tag   = tag_s2;
	assign sec_rem   = rem_s2;
	assign sec_s     = s_s2;
	assign sec_v     = val_s2;
	assign sec_p     = p_s2;

endmodule

// File: rtl/hsvc_frac.sv
// ----------------------------------------------------------------------------
// HSV sector fraction
// f = floor(rem * 2^FRAC_BITS / 3840), taken as a shift by 8 and a divide
// by 15 through a reciprocal multiply (stage 3) and a one-step fixup (stage 4).
// ----------------------------------------------------------------------------
module hsvc_frac #(
	parameter int FRAC_BITS = hsvc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sec_valid,
	output logic                          sec_ready,
	input  hsvc_pkg::tag_t                sec_tag,
	input  logic [hsvc_pkg::REM_W-1:0]    sec_rem,
	input  logic [FRAC_BITS:0]            sec_s,
	input  logic [FRAC_BITS:0]            sec_v,
	input  logic [FRAC_BITS:0]            sec_p,
	output logic                          frc_valid,
	input  logic                          frc_ready,
	output hsvc_pkg::tag_t                frc_tag,
	output logic [FRAC_BITS-1:0]          frc_f,
	output logic [FRAC_BITS:0]            frc_s,
	output logic [FRAC_BITS:0]            frc_v,
	output logic [FRAC_BITS:0]            frc_p
);

	localparam int UW = FRAC_BITS + 1;
	localparam int NW = FRAC_BITS + 4;
	localparam int MW = NW - 3;
	localparam logic [MW-1:0] RECIP = MW'((1 << NW) / 15);

	logic [NW-1:0]      n;
	logic [NW+MW-1:0]   prod;

	// Stage 3: estimate, low by at most one
	logic               v_s3;
	hsvc_pkg::tag_t     tag_s3;
	logic [NW-1:0]      n_s3;
	logic [FRAC_BITS-1:0] q0_s3;
	logic [UW-1:0]      s_s3;
	logic [UW-1:0]      val_s3;
	logic [UW-1:0]      p_s3;
	logic               s3_ready;

	// Stage 4: corrected fraction
	logic               v_s4;
	hsvc_pkg::tag_t     tag_s4;
	logic [FRAC_BITS-1:0] f_s4;
	logic [UW-1:0]      s_s4;
	logic [UW-1:0]      val_s4;
	logic [UW-1:0]      p_s4;
	logic               s4_ready;

	logic [NW-1:0]      times15;
	logic [NW-1:0]      resid;

	always_comb begin
		n       = NW'(sec_rem) << (FRAC_BITS - 8);
		prod    = (NW+MW)'(n) * (NW+MW)'(RECIP);
		times15 = (NW'(q0_s3) << 4) - NW'(q0_s3);
		resid   = n_s3 - times15;
	end

	assign s3_ready  = !v_s3 || s4_ready;
	assign s4_ready  = !v_s4 || frc_ready;
	assign sec_ready = s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s3_ready) begin
				v_s3 <= sec_valid;
			end
			if (s4_ready) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && sec_valid) begin
			tag_s3 <= sec_tag;
			n_s3   <= n;
			q0_s3  <= prod[NW +: FRAC_BITS];
			s_s3   <= sec_s;
			val_s3 <= sec_v;
			p_s3   <= sec_p;
		end
		if (s4_ready && v_s3) begin
			tag_s4 <= tag_s3;
			f_s4   <= q0_s3 + FRAC_BITS'(resid >= NW'(15));
			s_s4   <= s_s3;
			val_s4 <= val_s3;
			p_s4   <= p_s3;
		end
	end

	assign frc_valid = v_s4;
	assign frc_tag   = tag_s4;
	assign frc_f     = f_s4;
	assign frc_s     = s_s4;
	assign frc_v     = val_s4;
	assign frc_p     = p_s4;

endmodule

// File: rtl/hsvc_mix.sv
// ----------------------------------------------------------------------------
// HSV channel mixer
// Stage 5 scales s by f and 1-f, stage 6 forms q and t, stage 7 picks the
// channels by sector and holds the result beat.
// ----------------------------------------------------------------------------
module hsvc_mix #(
	parameter int FRAC_BITS = hsvc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frc_valid,
	output logic                          frc_ready,
	input  hsvc_pkg::tag_t                frc_tag,
	input  logic [FRAC_BITS-1:0]          frc_f,
	input  logic [FRAC_BITS:0]            frc_s,
	input  logic [FRAC_BITS:0]            frc_v,
	input  logic [FRAC_BITS:0]            frc_p,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [hsvc_pkg::CHAN_W-1:0]   red,
	output logic [hsvc_pkg::CHAN_W-1:0]   green,
	output logic [hsvc_pkg::CHAN_W-1:0]   blue
);

	localparam int UW = FRAC_BITS + 1;
	localparam int PW = 2 * UW;
	localparam logic [UW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [UW-1:0] HALF = ONE >> 1;

	// Stage 5
	logic               v_s5;
	hsvc_pkg::tag_t     tag_s5;
	logic [UW-1:0]      sf_s5;
	logic [UW-1:0]      sg_s5;
	logic [UW-1:0]      val_s5;
	logic [UW-1:0]      p_s5;
	logic               s5_ready;

	// Stage 6
	logic               v_s6;
	hsvc_pkg::tag_t     tag_s6;
	logic [UW-1:0]      q_s6;
	logic [UW-1:0]      t_s6;
	logic [UW-1:0]      val_s6;
	logic [UW-1:0]      p_s6;
	logic               s6_ready;

	// Stage 7, output beat
	logic                         v_s7;
	logic [hsvc_pkg::CHAN_W-1:0]  red_s7;
	logic [hsvc_pkg::CHAN_W-1:0]  green_s7;
	logic [hsvc_pkg::CHAN_W-1:0]  blue_s7;
	logic                         s7_ready;

	logic [PW-1:0] sf_prod, sg_prod, q_prod, t_prod;
	logic [UW-1:0] r_sel, g_sel, b_sel;

	always_comb begin
		sf_prod = PW'(frc_s) * PW'(UW'(frc_f)) + PW'(HALF);
		sg_prod = PW'(frc_s) * PW'(ONE - UW'(frc_f)) + PW'(HALF);
		q_prod  = PW'(val_s5) * PW'(ONE - sf_s5) + PW'(HALF);
		t_prod  = PW'(val_s5) * PW'(ONE - sg_s5) + PW'(HALF);
	end

	always_comb begin
		unique case (tag_s6.sector)
			hsvc_pkg::SEC_RED: begin
				r_sel = val_s6; g_sel = t_s6;   b_sel = p_s6;
			end
			hsvc_pkg::SEC_YELLOW: begin
				r_sel = q_s6;   g_sel = val_s6; b_sel = p_s6;
			end
			hsvc_pkg::SEC_GREEN: begin
				r_sel = p_s6;   g_sel = val_s6; b_sel = t_s6;
			end
			hsvc_pkg::SEC_CYAN: begin
				r_sel = p_s6;   g_sel = q_s6;   b_sel = val_s6;
			end
			hsvc_pkg::SEC_BLUE: begin
				r_sel = t_s6;   g_sel = p_s6;   b_sel = val_s6;
			end
			default: begin
				r_sel = val_s6; g_sel = p_s6;   b_sel = q_s6;
			end
		endcase
		if (tag_s6.gray) begin
			r_sel = val_s6;
			g_sel = val_s6;
			b_sel = val_s6;
		end
	end

	assign s5_ready  = !v_s5 || s6_ready;
	assign s6_ready  = !v_s6 || s7_ready;
	assign s7_ready  = !v_s7 || rgb_ready;
	assign frc_ready = s5_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (s5_ready) begin
				v_s5 <= frc_valid;
			end
			if (s6_ready) begin
				v_s6 <= v_s5;
			end
			if (s7_ready) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s5_ready && frc_valid) begin
			tag_s5 <= frc_tag;
			sf_s5  <= sf_prod[FRAC_BITS +: UW];
			sg_s5  <= sg_prod[FRAC_BITS +: UW];
			val_s5 <= frc_v;
			p_s5   <= frc_p;
		end
		if (s6_ready && v_s5) begin
			tag_s6 <= tag_s5;
			q_s6   <= q_prod[FRAC_BITS +: UW];
			t_s6   <= t_prod[FRAC_BITS +: UW];
			val_s6 <= val_s5;
			p_s6   <= p_s5;
		end
		if (s7_ready && v_s6) begin
			red_s7   <= hsvc_pkg::CHAN_W'(r_sel);
			green_s7 <= hsvc_pkg::CHAN_W'(g_sel);
			blue_s7  <= hsvc_pkg::CHAN_W'(b_sel);
		end
	end

	assign rgb_valid = v_s7;
	assign red       = red_s7;
	assign green     = green_s7;
	assign blue      = blue_s7;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point hexcone HSV to RGB, one pixel per clock while rgb_ready is
// high. Hue comes in 1/64 degree units and is wrapped into one turn;
// saturation and value are clamped to [0, 1.0] with 1.0 = 2^FRAC_BITS,
// and the channels leave as 15-bit fields. Each accepted beat passes
// seven register stages, the last one driving rgb_valid: hue wrap and
// clamping, sector search with p, the reciprocal multiply for f, its
// one-step fixup, s*f and s*(1-f), q and t, and the sector pick into the
// output register. A new beat enters every clock unless a stall holds it.
// Every stage carries its own valid bit, so hsv_ready drops only when all
// seven stages hold a pixel and the output beat is not being taken; a
// stall anywhere holds the data in place and a gap is closed up by the
// stages behind it. Zero saturation gives gray with all channels equal to
// the clamped value. There is no state across pixels and no configuration.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = hsvc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                hsv_valid,
	output logic                                hsv_ready,
	input  logic signed [hsvc_pkg::IN_W-1:0]    hue,
	input  logic signed [hsvc_pkg::IN_W-1:0]    saturation,
	input  logic signed [hsvc_pkg::IN_W-1:0]    brightness,
	output logic                                rgb_valid,
	input  logic                                rgb_ready,
	output logic [hsvc_pkg::CHAN_W-1:0]         red,
	output logic [hsvc_pkg::CHAN_W-1:0]         green,
	output logic [hsvc_pkg::CHAN_W-1:0]         blue
);

	// Front end to fraction unit: sector, remainder, s, v and p.
	logic                          sec_valid;
	logic                          sec_ready;
	hsvc_pkg::tag_t                sec_tag;
	logic [hsvc_pkg::REM_W-1:0]    sec_rem;
	logic [FRAC_BITS:0]            sec_s;
	logic [FRAC_BITS:0]            sec_v;
	logic [FRAC_BITS:0]            sec_p;

	// Fraction unit to mixer: f joins the carried fields.
	logic                          frc_valid;
	logic                          frc_ready;
	hsvc_pkg::tag_t                frc_tag;
	logic [FRAC_BITS-1:0]          frc_f;
	logic [FRAC_BITS:0]            frc_s;
	logic [FRAC_BITS:0]            frc_v;
	logic [FRAC_BITS:0]            frc_p;

	hsvc_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.sec_valid  (sec_valid),
		.sec_ready  (sec_ready),
		.sec_tag    (sec_tag),
		.sec_rem    (sec_rem),
		.sec_s      (sec_s),
		.sec_v      (sec_v),
		.sec_p      (sec_p)
	);

	hsvc_frac #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.sec_valid (sec_valid),
		.sec_ready (sec_ready),
		.sec_tag   (sec_tag),
		.sec_rem   (sec_rem),
		.sec_s     (sec_s),
		.sec_v     (sec_v),
		.sec_p     (sec_p),
		.frc_valid (frc_valid),
		.frc_ready (frc_ready),
		.frc_tag   (frc_tag),
		.frc_f     (frc_f),
		.frc_s     (frc_s),
		.frc_v     (frc_v),
		.frc_p     (frc_p)
	);

	hsvc_mix #(
		.FRAC_BITS (FRAC_BITS)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.frc_valid (frc_valid),
		.frc_ready (frc_ready),
		.frc_tag   (frc_tag),
		.frc_f     (frc_f),
		.frc_s     (frc_s),
		.frc_v     (frc_v),
		.frc_p     (frc_p),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// An empty output stage means every stage behind it can advance.
	`HSVC_ASSERT_IMPL(a_drain_ready, !rgb_valid, hsv_ready, "input stalled with empty output")
	// The gray flag must track the saturation it was derived from.
	`HSVC_ASSERT_IMPL(a_gray_flag, frc_valid, frc_tag.gray == (frc_s == '0), "gray flag out of step with saturation")
	// With zero saturation p reduces exactly to v.
	`HSVC_ASSERT_IMPL(a_gray_p, frc_valid && frc_tag.gray, frc_p == frc_v, "p differs from v on gray pixel")
	// A stalled fraction beat must hold until the mixer takes it.
	`HSVC_ASSERT_NEXT(a_frc_hold, frc_valid && !frc_ready, frc_valid && $stable(frc_f) && $stable(frc_tag), "fraction beat changed while stalled")

endmodule
